// ===== rtl/clut4_pkg.sv =====
// Shared types, constants and color decode for the 4bpp CLUT texel decoder.
// No dependencies.
package clut4_pkg;

  localparam int EntryW = 16;
  localparam int TabDepth = 16;
  localparam int IdxW = $clog2(TabDepth);
  localparam int PixW = 32;
  localparam int InDataW = 32;

  // in_tdata bit positions
  localparam int TIdxLsb = 0;
  localparam int TColLsb = TIdxLsb + IdxW;
  localparam int PByteLsb = TColLsb + EntryW;
  localparam int EmitLoBit = PByteLsb + 8;
  localparam int EmitHiBit = EmitLoBit + 1;

  // in_tuser action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // 8.226 in 4.16 fixed point
  localparam logic [19:0] SCALE_NUM = 20'd539099;
  localparam logic [7:0] ALPHA_FULL = 8'hFF;
  localparam logic [7:0] ALPHA_HALF = 8'h7F;
  localparam logic [15:0] ENTRY_FLAG_ONLY = 16'h8000;

  typedef logic [EntryW-1:0] entry_t;
  typedef logic [PixW-1:0] pixel_t;

  function automatic logic [7:0] scale5(input logic [4:0] v);
    logic [24:0] prod;
    prod = 25'(v) * 25'(SCALE_NUM);
    return prod[23:16];
  endfunction

  function automatic pixel_t decode_entry(input entry_t e, input logic mode);
    logic [7:0] alpha;
    pixel_t pix;
    alpha = (mode && e[15]) ? ALPHA_HALF : ALPHA_FULL;
    pix = {alpha, scale5(e[4:0]), scale5(e[9:5]), scale5(e[14:10])};
    if (e == '0) begin
      pix = '0;
    end else if (mode && e == ENTRY_FLAG_ONLY) begin
      pix = {ALPHA_HALF, 24'h000000};
    end
    return pix;
  endfunction

endpackage

// ===== rtl/clut_4bpp_texel_to_rgba_core.sv =====
// Top level of the 4bpp CLUT texel decoder: color table, nibble holding stage
// and output register. Depends on clut4_pkg.
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  in_tuser action, in_tdata load/pixel fields
// out_     out  out_tvalid/out_tready out_tdata ARGB pixel, out_tlast last of byte
// cfg_     in   cfg_we               cfg_wdata semitransparency mode
//
// A pixel item reads both table entries at its accept edge into a holding stage;
// the output register then takes one pixel per cycle unless stalled, so a byte
// with both nibbles enabled holds off the next item until its high pixel moves.
// Results pass the holding stage, then the output register. in_tready drops while
// the holding stage keeps a pixel it cannot pass on; out_tready low stalls both stages.
// Reset (rst_n low, synchronous) clears valid state and the mode; table contents are kept.
module clut_4bpp_texel_to_rgba_core
  import clut4_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [InDataW-1:0] in_tdata,   // table_index, table_colour, packed_byte,
                                         // emit_low, emit_high, zero pad
  input  logic               in_tuser,   // action
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [PixW-1:0]    out_tdata,  // pixel_argb
  output logic               out_tlast,  // last_of_byte
  input  logic               cfg_we,
  input  logic               cfg_wdata   // semitransparency_mode
);

  entry_t ctab_mem [TabDepth];

  logic             mode_r;
  entry_t           ent_lo_r, ent_hi_r;
  logic             pend_lo_r, pend_hi_r;
  logic             pend_lo_nxt, pend_hi_nxt;
  logic             out_valid_r, out_valid_nxt;
  pixel_t           out_data_r;
  logic             out_last_r;

  logic             out_ld, mv_lo, mv_hi, lo_left, hi_left;
  logic             acc, pix_acc, load_acc;
  logic [IdxW-1:0]  wr_idx, rd_idx_lo, rd_idx_hi;
  entry_t           sel_ent;

  assign wr_idx    = in_tdata[TIdxLsb +: IdxW];
  assign rd_idx_lo = in_tdata[PByteLsb +: IdxW];
  assign rd_idx_hi = in_tdata[PByteLsb + IdxW +: IdxW];

  assign out_ld  = !out_valid_r || out_tready;
  assign mv_lo   = out_ld && pend_lo_r;
  assign mv_hi   = out_ld && !pend_lo_r && pend_hi_r;
  assign lo_left = pend_lo_r && !mv_lo;
  assign hi_left = pend_hi_r && !mv_hi;

  assign in_tready = !lo_left && !hi_left;
  assign acc       = in_tvalid && in_tready;
  assign pix_acc   = acc && (in_tuser == ACT_PIXEL);
  assign load_acc  = acc && (in_tuser == ACT_LOAD);

  assign pend_lo_nxt   = pix_acc ? in_tdata[EmitLoBit] : lo_left;
  assign pend_hi_nxt   = pix_acc ? in_tdata[EmitHiBit] : hi_left;
  assign out_valid_nxt = (mv_lo || mv_hi) ? 1'b1 : (out_ld ? 1'b0 : out_valid_r);
  assign sel_ent       = pend_lo_r ? ent_lo_r : ent_hi_r;

  always_ff @(posedge clk) begin
    if (load_acc) begin
      ctab_mem[wr_idx] <= in_tdata[TColLsb +: EntryW];
    end
    if (pix_acc) begin
      ent_lo_r <= ctab_mem[rd_idx_lo];
      ent_hi_r <= ctab_mem[rd_idx_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      pend_lo_r   <= 1'b0;
      pend_hi_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      pend_lo_r   <= pend_lo_nxt;
      pend_hi_r   <= pend_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv_lo || mv_hi) begin
      out_data_r <= decode_entry(sel_ent, mode_r);
      out_last_r <= pend_lo_r ? !pend_hi_r : 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/clut4_checker.sv =====
// Port-level checks for clut_4bpp_texel_to_rgba_core, attached by bind.
// Depends on clut4_pkg.
module clut4_checker
  import clut4_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic [InDataW-1:0] in_tdata,
  input logic               in_tuser,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [PixW-1:0]    out_tdata,
  input logic               out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |=> out_tvalid)
    else $error("second pixel of a byte did not follow");

  a_busy_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> out_tvalid)
    else $error("input stalled with no output item pending");

  a_two_pixel_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_PIXEL && in_tdata[EmitLoBit]
      && in_tdata[EmitHiBit] |=> !in_tready)
    else $error("input taken while a two-pixel byte is pending");

endmodule

bind clut_4bpp_texel_to_rgba_core clut4_checker u_clut4_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== bench/clut_4bpp_texel_to_rgba_core_tb.sv =====
// Testbench for clut_4bpp_texel_to_rgba_core: loads the color table, decodes packed
// 4bpp bytes in both alpha modes and checks every ARGB pixel against a local decoder.
// Depends on clut4_pkg and the core RTL.
module clut_4bpp_texel_to_rgba_core_tb;
  import clut4_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 4;
  localparam int RandomItems = 470;

  typedef struct packed {
    pixel_t argb;
    logic   last;
  } expected_pixel_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic               in_tuser = ACT_LOAD;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [PixW-1:0]    out_tdata;
  logic               out_tlast;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;

  entry_t          palette_shadow [TabDepth];
  logic            mode_shadow = 1'b0;
  expected_pixel_t pending_pixels [$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;

  clut_4bpp_texel_to_rgba_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // 5-bit channel widened to 8 bits: floor(v * 8.226) in 16.16 fixed point
  function automatic logic [7:0] widen_channel(input logic [4:0] v);
    int unsigned scaled;
    scaled = (32'(v) * 32'd539099) >> 16;
    return scaled[7:0];
  endfunction

  function automatic pixel_t argb_of_entry(input entry_t e, input logic half_alpha_mode);
    logic [23:0] rgb;
    rgb = {widen_channel(e[4:0]), widen_channel(e[9:5]), widen_channel(e[14:10])};
    if (e == 16'h0000) return 32'h0000_0000;
    if (half_alpha_mode && e == 16'h8000) return 32'h7F00_0000;
    if (half_alpha_mode && e[15]) return {8'h7F, rgb};
    return {8'hFF, rgb};
  endfunction

  function automatic logic [InDataW-1:0] pack_in_fields(input logic [3:0] idx,
      input entry_t col, input logic [7:0] pb, input logic lo, input logic hi);
    logic [InDataW-1:0] w;
    w = '0;
    w[TIdxLsb +: IdxW] = idx;
    w[TColLsb +: EntryW] = col;
    w[PByteLsb +: 8] = pb;
    w[EmitLoBit] = lo;
    w[EmitHiBit] = hi;
    return w;
  endfunction

  task automatic predict_pixels(input logic act, input logic [3:0] idx, input entry_t col,
      input logic [7:0] pb, input logic lo, input logic hi);
    expected_pixel_t p;
    if (act == ACT_LOAD) begin
      palette_shadow[idx] = col;
    end else begin
      if (lo) begin
        p.argb = argb_of_entry(palette_shadow[pb[3:0]], mode_shadow);
        p.last = !hi;
        pending_pixels.push_back(p);
      end
      if (hi) begin
        p.argb = argb_of_entry(palette_shadow[pb[7:4]], mode_shadow);
        p.last = 1'b1;
        pending_pixels.push_back(p);
      end
    end
  endtask

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_item(input logic act, input logic [3:0] idx, input entry_t col,
      input logic [7:0] pb, input logic lo, input logic hi);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= pack_in_fields(idx, col, pb, lo, hi);
    do @(posedge clk); while (!in_tready);
    predict_pixels(act, idx, col, pb, lo, hi);
  endtask

  task automatic send_pixel(input logic [7:0] pb, input logic lo, input logic hi);
    send_item(ACT_PIXEL, 4'($urandom), 16'($urandom), pb, lo, hi);
  endtask

  task automatic send_load(input logic [3:0] idx, input entry_t col);
    send_item(ACT_LOAD, idx, col, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_alpha_mode(input logic m);
    drain_pixels();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_shadow = m;
  endtask

  task automatic check_pixel();
    expected_pixel_t want;
    if (pending_pixels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected pixel %h last %b", out_tdata, out_tlast);
    end else begin
      want = pending_pixels.pop_front();
      if (out_tdata !== want.argb || out_tlast !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("pixel mismatch: expected %h last %b, got %h last %b",
                   want.argb, want.last, out_tdata, out_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_pixel();
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // every entry gets written here first, so no later pixel reads an unwritten one
  task automatic test_table_load();
    entry_t seeds [11];
    seeds = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h001F, 16'h03E0,
              16'h7C00, 16'h83E0, 16'h0001, 16'h8421, 16'h0421};
    set_alpha_mode(1'b0);
    for (int i = 0; i < TabDepth; i++)
      send_load(4'(i), (i < 11) ? seeds[i] : entry_t'($urandom));
  endtask

  task automatic test_full_alpha_pixels();
    set_alpha_mode(1'b0);
    send_pixel(8'h10, 1'b1, 1'b1);
    send_pixel(8'h32, 1'b1, 1'b0);
    send_pixel(8'h54, 1'b0, 1'b1);
    send_pixel(8'h76, 1'b0, 1'b0);
  endtask

  task automatic test_half_alpha_pixels();
    set_alpha_mode(1'b1);
    send_pixel(8'h10, 1'b1, 1'b1);
    send_pixel(8'h23, 1'b1, 1'b1);
    send_pixel(8'h97, 1'b1, 1'b0);
    send_pixel(8'hAF, 1'b0, 1'b1);
  endtask

  task automatic send_random_item();
    entry_t special [4];
    entry_t col;
    int     pick;
    special = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF};
    if ($urandom_range(99) < 20) begin
      col = ($urandom_range(3) == 0) ? special[$urandom_range(3)] : entry_t'($urandom);
      send_load(4'($urandom), col);
    end else begin
      pick = $urandom_range(9);
      send_pixel(8'($urandom), pick <= 6 && pick != 5 ? 1'b1 : (pick == 5),
                 pick <= 4 || pick == 7 || pick == 8);
    end
  endtask

  task automatic test_random_traffic(input int n, input int s_pct, input int r_pct,
      input logic first_mode);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    set_alpha_mode(first_mode);
    for (int i = 0; i < n / 2; i++) send_random_item();
    set_alpha_mode(!first_mode);
    for (int i = n / 2; i < n; i++) send_random_item();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_table_load();
    test_full_alpha_pixels();
    test_half_alpha_pixels();
    test_random_traffic(RandomItems, 12, 67, 1'b0);
    test_random_traffic(RandomItems, 67, 12, 1'b1);
    test_random_traffic(RandomItems, 0, 0, 1'b0);
    drain_pixels();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
